// ----- design/shpr_pkg.sv -----
// Shared types, constants and the basis scale table for the pixel relighting block.
package shpr_pkg;

    localparam int TERMS     = 9;
    localparam int TERM_W    = 4;
    localparam int LIGHT_W   = 16;
    localparam int WEIGHT_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SCALE_W   = 18;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_X = 2'd0,
        CFG_LIGHT_Y = 2'd1,
        CFG_LIGHT_Z = 2'd2
    } t_cfg_idx;

    // Basis terms in stream order.
    typedef enum logic [TERM_W-1:0] {
        TERM_DC   = 4'd0,
        TERM_Y    = 4'd1,
        TERM_Z    = 4'd2,
        TERM_X    = 4'd3,
        TERM_XY   = 4'd4,
        TERM_YZ   = 4'd5,
        TERM_ZZ   = 4'd6,
        TERM_XZ   = 4'd7,
        TERM_XXYY = 4'd8
    } t_term;

    // Basis constants with 16 fraction bits.
    localparam logic signed [SCALE_W-1:0] K_C0 = 18'sd18487;
    localparam logic signed [SCALE_W-1:0] K_C1 = 18'sd32021;
    localparam logic signed [SCALE_W-1:0] K_C2 = 18'sd71601;
    localparam logic signed [SCALE_W-1:0] K_C3 = 18'sd20670;
    localparam logic signed [SCALE_W-1:0] K_C4 = 18'sd35801;

    // Unity in Q1.14, also the reset value of the z component.
    localparam logic signed [LIGHT_W-1:0] LIGHT_ONE = 16'sd16384;

    // Handshake control from the top level to the accumulator.
    typedef struct packed {
        logic en;
        logic take;
        logic last;
    } t_pipe_ctl;

    function automatic logic signed [SCALE_W-1:0] basis_scale(input logic [TERM_W-1:0] term);
        logic signed [SCALE_W-1:0] k;
        case (term)
            TERM_DC:                  k = K_C0;
            TERM_Y, TERM_Z, TERM_X:   k = K_C1;
            TERM_XY, TERM_YZ, TERM_XZ: k = K_C2;
            TERM_ZZ:                  k = K_C3;
            TERM_XXYY:                k = K_C4;
            default:                  k = K_C0;
        endcase
        return k;
    endfunction

endpackage

// ----- design/shpr_weight_gen.sv -----
// Light direction registers and the pipelined generator of the nine basis weights.
module shpr_weight_gen (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [shpr_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [shpr_pkg::LIGHT_W-1:0]             i_cfg_data,
    input  logic [shpr_pkg::TERM_W-1:0]              i_term,
    output logic signed [shpr_pkg::WEIGHT_W-1:0]     o_weight,
    output logic                                     o_busy
);
    import shpr_pkg::*;

    localparam int PROD_W  = 2 * LIGHT_W;
    localparam int DIFF_W  = PROD_W + 1;
    localparam int SCL_W   = DIFF_W + SCALE_W;
    localparam int SHIFT   = 30;
    localparam int RES_W   = SCL_W - SHIFT;
    localparam logic signed [DIFF_W-1:0] ZZ_BIAS = DIFF_W'(64'sd268435456);
    localparam logic signed [SCL_W-1:0]  HALF    = SCL_W'(64'sd536870912);
    localparam logic signed [RES_W-1:0]  W_MAX   = RES_W'(32767);
    localparam logic signed [RES_W-1:0]  W_MIN   = -RES_W'(32768);

    logic signed [LIGHT_W-1:0]  r_light_x, r_light_y, r_light_z;
    logic                       r_issue;
    logic [TERM_W-1:0]          r_issue_idx;
    logic                       r_v1, r_v2, r_v3;
    logic [TERM_W-1:0]          r_i1, r_i2, r_i3;
    logic signed [PROD_W-1:0]   r_p1, r_p2;
    logic signed [DIFF_W-1:0]   r_d;
    logic signed [SCL_W-1:0]    r_m;
    logic signed [WEIGHT_W-1:0] r_weight [TERMS];

    logic                       w_cfg_hit;
    logic signed [LIGHT_W-1:0]  w_a, w_b;
    logic signed [DIFF_W-1:0]   w_p1x, w_p2x, w_d;
    logic signed [SCL_W-1:0]    w_rnd;
    logic signed [RES_W-1:0]    w_res;
    logic signed [WEIGHT_W-1:0] w_sat;

    assign w_cfg_hit = i_cfg_we && (i_cfg_index == CFG_LIGHT_X ||
                                    i_cfg_index == CFG_LIGHT_Y ||
                                    i_cfg_index == CFG_LIGHT_Z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x   <= '0;
            r_light_y   <= '0;
            r_light_z   <= LIGHT_ONE;
            r_issue     <= 1'b1;
            r_issue_idx <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
        end else if (w_cfg_hit) begin
            // A new direction restarts the whole table and drops work in flight.
            case (i_cfg_index)
                CFG_LIGHT_X: r_light_x <= $signed(i_cfg_data);
                CFG_LIGHT_Y: r_light_y <= $signed(i_cfg_data);
                default:     r_light_z <= $signed(i_cfg_data);
            endcase
            r_issue     <= 1'b1;
            r_issue_idx <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
        end else begin
            r_v1 <= r_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_issue) begin
                if (r_issue_idx == TERM_W'(TERMS - 1)) begin
                    r_issue     <= 1'b0;
                    r_issue_idx <= '0;
                end else begin
                    r_issue_idx <= r_issue_idx + 1'b1;
                end
            end
        end
    end

    // Operand choice for the first product; the y*y product is only used by the last term.
    always_comb begin
        case (r_issue_idx)
            TERM_DC:   begin w_a = LIGHT_ONE; w_b = LIGHT_ONE; end
            TERM_Y:    begin w_a = r_light_y; w_b = LIGHT_ONE; end
            TERM_Z:    begin w_a = r_light_z; w_b = LIGHT_ONE; end
            TERM_X:    begin w_a = r_light_x; w_b = LIGHT_ONE; end
            TERM_XY:   begin w_a = r_light_x; w_b = r_light_y; end
            TERM_YZ:   begin w_a = r_light_y; w_b = r_light_z; end
            TERM_ZZ:   begin w_a = r_light_z; w_b = r_light_z; end
            TERM_XZ:   begin w_a = r_light_x; w_b = r_light_z; end
            TERM_XXYY: begin w_a = r_light_x; w_b = r_light_x; end
            default:   begin w_a = LIGHT_ONE; w_b = LIGHT_ONE; end
        endcase
    end

    assign w_p1x = {r_p1[PROD_W-1], r_p1};
    assign w_p2x = {r_p2[PROD_W-1], r_p2};

    always_comb begin
        case (r_i1)
            TERM_ZZ:   w_d = (w_p1x <<< 1) + w_p1x - ZZ_BIAS;
            TERM_XXYY: w_d = w_p1x - w_p2x;
            default:   w_d = w_p1x;
        endcase
    end

    // Round half up, floor shift, then saturate to Q1.14.
    assign w_rnd = r_m + HALF;
    assign w_res = w_rnd[SCL_W-1:SHIFT];

    always_comb begin
        if (w_res > W_MAX) begin
            w_sat = WEIGHT_W'(W_MAX);
        end else if (w_res < W_MIN) begin
            w_sat = WEIGHT_W'(W_MIN);
        end else begin
            w_sat = w_res[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= r_issue_idx;
        r_p1 <= w_a * w_b;
        r_p2 <= r_light_y * r_light_y;
        r_i2 <= r_i1;
        r_d  <= w_d;
        r_i3 <= r_i2;
        r_m  <= basis_scale(r_i2) * r_d;
        if (r_v3) begin
            r_weight[r_i3] <= w_sat;
        end
    end

    assign o_weight = r_weight[i_term];
    assign o_busy   = r_issue | r_v1 | r_v2 | r_v3;

endmodule

// ----- design/shpr_accum.sv -----
// Input register, per-channel products and the running channel sums.
module shpr_accum #(
    parameter int COEF_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  shpr_pkg::t_pipe_ctl                   i_ctl,
    input  logic signed [COEF_BITS-1:0]           i_coef_red,
    input  logic signed [COEF_BITS-1:0]           i_coef_green,
    input  logic signed [COEF_BITS-1:0]           i_coef_blue,
    input  logic signed [shpr_pkg::WEIGHT_W-1:0]  i_weight,
    output logic                                  o_fin_valid,
    output logic signed [COEF_BITS+19:0]          o_fin_red,
    output logic signed [COEF_BITS+19:0]          o_fin_green,
    output logic signed [COEF_BITS+19:0]          o_fin_blue
);
    import shpr_pkg::*;

    localparam int PROD_W = COEF_BITS + WEIGHT_W;
    localparam int SUM_W  = COEF_BITS + 20;

    logic                       r_v1, r_last1, r_v2, r_last2, r_fin_v;
    logic signed [COEF_BITS-1:0] r_coef [3];
    logic signed [WEIGHT_W-1:0] r_w1;
    logic signed [PROD_W-1:0]   r_prod [3];
    logic signed [SUM_W-1:0]    r_sum [3];
    logic signed [SUM_W-1:0]    r_fin [3];
    logic signed [SUM_W-1:0]    w_total [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_total[c] = r_sum[c] + SUM_W'(r_prod[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_last1 <= 1'b0;
            r_v2    <= 1'b0;
            r_last2 <= 1'b0;
            r_fin_v <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
            end
        end else if (i_ctl.en) begin
            r_v1    <= i_ctl.take;
            r_last1 <= i_ctl.last;
            r_v2    <= r_v1;
            r_last2 <= r_last1;
            r_fin_v <= r_v2 && r_last2;
            if (r_v2) begin
                for (int c = 0; c < 3; c++) begin
                    r_sum[c] <= r_last2 ? '0 : w_total[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.take) begin
                r_coef[0] <= i_coef_red;
                r_coef[1] <= i_coef_green;
                r_coef[2] <= i_coef_blue;
                r_w1      <= i_weight;
            end
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= r_coef[c] * r_w1;
                r_fin[c]  <= w_total[c];
            end
        end
    end

    assign o_fin_valid = r_fin_v;
    assign o_fin_red   = r_fin[0];
    assign o_fin_green = r_fin[1];
    assign o_fin_blue  = r_fin[2];

endmodule

// ----- design/shpr_byte_out.sv -----
// Clamp to unity, scale by 255 and hold the result bytes in the output register.
module shpr_byte_out #(
    parameter int COEF_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_stall,
    input  logic                          i_fin_valid,
    input  logic signed [COEF_BITS+19:0]  i_fin_red,
    input  logic signed [COEF_BITS+19:0]  i_fin_green,
    input  logic signed [COEF_BITS+19:0]  i_fin_blue,
    output logic                          o_valid,
    output logic [7:0]                    o_red,
    output logic [7:0]                    o_green,
    output logic [7:0]                    o_blue
);
    import shpr_pkg::*;

    localparam int SUM_W    = COEF_BITS + 20;
    localparam int SUM_FRAC = COEF_BITS + 10;
    localparam int SCALED_W = SUM_FRAC + 8;

    logic                      r_valid;
    logic [7:0]                r_byte [3];
    logic signed [SUM_W-1:0]   w_fin [3];
    logic [SUM_FRAC-1:0]       w_lo [3];
    logic [SCALED_W-1:0]       w_scaled [3];
    logic [7:0]                w_byte [3];
    logic                      w_load;

    assign w_fin[0] = i_fin_red;
    assign w_fin[1] = i_fin_green;
    assign w_fin[2] = i_fin_blue;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_lo[c]     = w_fin[c][SUM_FRAC-1:0];
            // x * 255 as (x << 8) - x
            w_scaled[c] = {w_lo[c], 8'h00} - {8'h00, w_lo[c]};
            if (w_fin[c][SUM_W-1]) begin
                w_byte[c] = 8'h00;
            end else if (|w_fin[c][SUM_W-2:SUM_FRAC]) begin
                w_byte[c] = 8'hFF;
            end else begin
                w_byte[c] = w_scaled[c][SCALED_W-1:SUM_FRAC];
            end
        end
    end

    assign w_load = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_fin_valid) begin
            for (int c = 0; c < 3; c++) begin
                r_byte[c] <= w_byte[c];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_byte[0];
    assign o_green = r_byte[1];
    assign o_blue  = r_byte[2];

endmodule

// ----- design/sh_pixel_relight.sv -----
// Top level of the second-order spherical-harmonic pixel relighting block.
//
//  Channel   Direction  Handshake              Payload
//  --------  ---------  ---------------------  -------------------------------------
//  coef in   input      i_valid / o_stall      i_coef_red, i_coef_green, i_coef_blue
//  pixel out output     o_valid / i_stall      o_red, o_green, o_blue
//  config    input      i_cfg_we               i_cfg_index, i_cfg_data
//
// One coefficient transaction is taken per cycle while o_stall is low; the ninth of
// a pixel passes the input, product and final sum registers before its bytes show in
// the output register. After reset and after every write of a light register the
// weight generator rebuilds the nine basis weights; o_stall stays high during that
// time. A pixel that waits on a stalled output sits in the output register, and a
// second finished pixel waits one stage behind it; only then does the input stall.
module sh_pixel_relight #(
    parameter int COEF_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COEF_BITS-1:0]         i_coef_red,
    input  logic signed [COEF_BITS-1:0]         i_coef_green,
    input  logic signed [COEF_BITS-1:0]         i_coef_blue,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [7:0]                          o_red,
    output logic [7:0]                          o_green,
    output logic [7:0]                          o_blue,
    input  logic                                i_cfg_we,
    input  logic [shpr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [shpr_pkg::LIGHT_W-1:0]        i_cfg_data
);
    import shpr_pkg::*;

    localparam int SUM_W = COEF_BITS + 20;

    logic [TERM_W-1:0]          r_term_count;
    logic                       w_busy;
    logic                       w_en;
    logic                       w_take;
    logic                       w_last;
    logic signed [WEIGHT_W-1:0] w_weight;
    t_pipe_ctl                  w_ctl;
    logic                       w_fin_valid;
    logic signed [SUM_W-1:0]    w_fin_red, w_fin_green, w_fin_blue;

    // The pipeline holds only when a finished pixel cannot move into a full,
    // stalled output register.
    assign w_en    = !(w_fin_valid && o_valid && i_stall);
    assign o_stall = w_busy || !w_en;
    assign w_take  = i_valid && !o_stall;
    assign w_last  = (r_term_count == TERM_W'(TERMS - 1));

    assign w_ctl.en   = w_en;
    assign w_ctl.take = w_take;
    assign w_ctl.last = w_last;

    // Term counter: selects the basis weight of each incoming transaction and marks
    // the last term of a pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= '0;
        end else if (w_take) begin
            r_term_count <= w_last ? '0 : r_term_count + 1'b1;
        end
    end

    shpr_weight_gen u_weight_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_term      (r_term_count),
        .o_weight    (w_weight),
        .o_busy      (w_busy)
    );

    shpr_accum #(
        .COEF_BITS (COEF_BITS)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_coef_red   (i_coef_red),
        .i_coef_green (i_coef_green),
        .i_coef_blue  (i_coef_blue),
        .i_weight     (w_weight),
        .o_fin_valid  (w_fin_valid),
        .o_fin_red    (w_fin_red),
        .o_fin_green  (w_fin_green),
        .o_fin_blue   (w_fin_blue)
    );

    shpr_byte_out #(
        .COEF_BITS (COEF_BITS)
    ) u_byte_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stall     (i_stall),
        .i_fin_valid (w_fin_valid),
        .i_fin_red   (w_fin_red),
        .i_fin_green (w_fin_green),
        .i_fin_blue  (w_fin_blue),
        .o_valid     (o_valid),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    // The term counter never runs past the last term of a pixel.
    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_term_count < TERM_W'(TERMS))
        else $error("term counter out of range");

    // A light register write blocks input while the weights are rebuilt.
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index == CFG_LIGHT_X || i_cfg_index == CFG_LIGHT_Y ||
                      i_cfg_index == CFG_LIGHT_Z)) |=> o_stall)
        else $error("input taken while weights are stale");

    // A waiting finished pixel behind a stalled output must hold the input.
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_valid && o_valid && i_stall) |-> o_stall)
        else $error("finished pixel could be overwritten");

    // A new result comes only from a finished pixel sum.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_fin_valid))
        else $error("output valid without a finished pixel");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the spherical-harmonic pixel relighting block.
module tb;
    import shpr_pkg::*;

    localparam int COEF_W        = 16;
    localparam int SUM_FRAC      = COEF_W - 4 + 14;
    localparam longint SUM_ONE   = longint'(1) << SUM_FRAC;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 700;

    // Basis constants with 16 fraction bits, rounded to nearest.
    localparam longint SCALE_C0 = 18487;
    localparam longint SCALE_C1 = 32021;
    localparam longint SCALE_C2 = 71601;
    localparam longint SCALE_C3 = 20670;
    localparam longint SCALE_C4 = 35801;

    localparam logic [15:0] COEF_MAX = 16'h7FFF;
    localparam logic [15:0] COEF_MIN = 16'h8000;
    // There is no register behind this index; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // One line of the directed script: a register write or a coefficient transaction.
    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [15:0]          reg_val;
        logic [15:0]          red;
        logic [15:0]          green;
        logic [15:0]          blue;
        logic                 typed;
        t_pixel               want;
    } t_script_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic signed [COEF_W-1:0]    i_coef_red = '0;
    logic signed [COEF_W-1:0]    i_coef_green = '0;
    logic signed [COEF_W-1:0]    i_coef_blue = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [7:0]                  o_red;
    logic [7:0]                  o_green;
    logic [7:0]                  o_blue;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [LIGHT_W-1:0]          i_cfg_data = '0;

    sh_pixel_relight #(
        .COEF_BITS(COEF_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_coef_red  (i_coef_red),
        .i_coef_green(i_coef_green),
        .i_coef_blue (i_coef_blue),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mirror of the block's state: light direction, weight table and running sums.
    logic signed [LIGHT_W-1:0]  light_x;
    logic signed [LIGHT_W-1:0]  light_y;
    logic signed [LIGHT_W-1:0]  light_z;
    logic signed [WEIGHT_W-1:0] basis_w [TERMS];
    longint                     color_sums [3];
    t_term                      next_term;

    t_pixel      expected_pixels [$];
    t_script_row relight_script [$];
    int          mismatches = 0;

    function automatic logic signed [WEIGHT_W-1:0] round_to_q14(input longint v, input int s);
        longint t;
        t = (v + (longint'(1) << (s - 1))) >>> s;
        if (t > 32767) begin
            t = 32767;
        end
        if (t < -32768) begin
            t = -32768;
        end
        return t[WEIGHT_W-1:0];
    endfunction

    function automatic void rebuild_weights();
        longint x;
        longint y;
        longint z;
        x = light_x;
        y = light_y;
        z = light_z;
        basis_w[TERM_DC]   = round_to_q14(SCALE_C0 << 14, 16);
        basis_w[TERM_Y]    = round_to_q14(SCALE_C1 * y, 16);
        basis_w[TERM_Z]    = round_to_q14(SCALE_C1 * z, 16);
        basis_w[TERM_X]    = round_to_q14(SCALE_C1 * x, 16);
        basis_w[TERM_XY]   = round_to_q14(SCALE_C2 * (x * y), 30);
        basis_w[TERM_YZ]   = round_to_q14(SCALE_C2 * (y * z), 30);
        basis_w[TERM_ZZ]   = round_to_q14(SCALE_C3 * (3 * z * z - (longint'(1) << 28)), 30);
        basis_w[TERM_XZ]   = round_to_q14(SCALE_C2 * (x * z), 30);
        basis_w[TERM_XXYY] = round_to_q14(SCALE_C4 * (x * x - y * y), 30);
    endfunction

    function automatic void apply_light_write(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [15:0] val);
        case (idx)
            CFG_LIGHT_X: light_x = val;
            CFG_LIGHT_Y: light_y = val;
            CFG_LIGHT_Z: light_z = val;
            default:     return;
        endcase
        rebuild_weights();
    endfunction

    function automatic logic [7:0] to_byte(input longint s);
        if (s < 0) begin
            s = 0;
        end
        if (s > SUM_ONE) begin
            s = SUM_ONE;
        end
        return 8'((s * 255) >>> SUM_FRAC);
    endfunction

    // Adds one term to the sums; returns 1 with the finished pixel after the last term.
    function automatic bit accumulate_term(input logic [15:0] r, input logic [15:0] g,
                                           input logic [15:0] b, output t_pixel px);
        longint w;
        w = basis_w[next_term];
        color_sums[0] += longint'($signed(r)) * w;
        color_sums[1] += longint'($signed(g)) * w;
        color_sums[2] += longint'($signed(b)) * w;
        px = '0;
        if (next_term != TERM_XXYY) begin
            next_term = t_term'(next_term + 1);
            return 1'b0;
        end
        px.red   = to_byte(color_sums[0]);
        px.green = to_byte(color_sums[1]);
        px.blue  = to_byte(color_sums[2]);
        color_sums = '{0, 0, 0};
        next_term = TERM_DC;
        return 1'b1;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) begin
            return 0;
        end else if (k < 85) begin
            return $urandom_range(1, 3);
        end else if (k < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Mostly values that keep the bytes off the clamp, plus extremes and raw noise.
    function automatic logic [15:0] pick_coef();
        int v;
        case ($urandom_range(0, 9))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2, 3:    return 16'($urandom);
            default: begin
                v = int'($urandom_range(0, 8192)) - 2048;
                return v[15:0];
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_light_value();
        int v;
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return LIGHT_ONE;
            3:       return -LIGHT_ONE;
            4, 5, 6: begin
                v = int'($urandom_range(0, 32768)) - 16384;
                return v[15:0];
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("t=%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Offers one coefficient transaction and predicts on acceptance. Called just
    // after a rising edge; valid stays high if the next transaction follows at once.
    task automatic send_coefs(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b, input logic typed,
                              input t_pixel want, input logic no_gap);
        int     gap;
        t_pixel px;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_coef_red   <= r;
        i_coef_green <= g;
        i_coef_blue  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (accumulate_term(r, g, b, px)) begin
            expected_pixels.push_back(typed ? want : px);
        end
    endtask

    // Holds the sender off until every pixel has been delivered and the pipe is empty.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_light(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        while (o_stall) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_light_write(idx, val);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Output side: runs of ready cycles broken by stall bursts, with long free stretches.
    int hold_left = 0;
    int free_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            i_stall <= 1'b0;
        end else begin
            free_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(0, 4);
            hold_left = pick_gap() + 1;
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : pixel_check
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel %0d/%0d/%0d",
                                          o_red, o_green, o_blue));
            end else begin
                want = expected_pixels.pop_front();
                if (o_red !== want.red) begin
                    report_mismatch($sformatf("red got %0d want %0d", o_red, want.red));
                end
                if (o_green !== want.green) begin
                    report_mismatch($sformatf("green got %0d want %0d", o_green, want.green));
                end
                if (o_blue !== want.blue) begin
                    report_mismatch($sformatf("blue got %0d want %0d", o_blue, want.blue));
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int     sent;
        int     phase_len;
        int     writes;
        logic   burst;
        t_pixel saturated;

        light_x    = '0;
        light_y    = '0;
        light_z    = LIGHT_ONE;
        color_sums = '{0, 0, 0};
        next_term  = TERM_DC;
        rebuild_weights();

        // Reset light: every weight is non-negative and the constant term is positive,
        // so a channel at the top coefficient clamps to 255 and one at the bottom to 0.
        saturated = '{red: 8'd255, green: 8'd0, blue: 8'd255};
        for (int t = 0; t < TERMS; t++) begin
            relight_script.push_back('{1'b0, '0, '0, COEF_MAX, COEF_MIN, COEF_MAX,
                                       t == TERMS - 1, saturated});
        end
        // Light far outside the unit sphere drives several weights into saturation;
        // the spare index must leave everything untouched.
        relight_script.push_back('{1'b1, CFG_LIGHT_X, 16'h8000, '0, '0, '0, 1'b0, '0});
        relight_script.push_back('{1'b1, CFG_LIGHT_Y, 16'h7FFF, '0, '0, '0, 1'b0, '0});
        relight_script.push_back('{1'b1, CFG_LIGHT_Z, 16'h8000, '0, '0, '0, 1'b0, '0});
        relight_script.push_back('{1'b1, CFG_SPARE_IDX, 16'hFFFF, '0, '0, '0, 1'b0, '0});
        relight_script.push_back('{1'b0, '0, '0, COEF_MAX, COEF_MAX, COEF_MIN, 1'b0, '0});
        relight_script.push_back('{1'b0, '0, '0, 16'h1000, 16'hF000, 16'h0800, 1'b0, '0});
        relight_script.push_back('{1'b0, '0, '0, 16'h2345, 16'h0123, 16'hFEDC, 1'b0, '0});
        relight_script.push_back('{1'b0, '0, '0, COEF_MIN, 16'h0400, COEF_MAX, 1'b0, '0});
        // A write in the middle of a pixel: later terms see the new weights.
        relight_script.push_back('{1'b1, CFG_LIGHT_X, LIGHT_ONE, '0, '0, '0, 1'b0, '0});
        relight_script.push_back('{1'b0, '0, '0, 16'h0800, 16'h0800, 16'h0800, 1'b0, '0});
        relight_script.push_back('{1'b0, '0, '0, 16'hFC00, 16'h1800, 16'h0200, 1'b0, '0});
        relight_script.push_back('{1'b0, '0, '0, 16'h3000, 16'hD000, 16'h0000, 1'b0, '0});
        relight_script.push_back('{1'b0, '0, '0, 16'h0001, 16'hFFFF, 16'h7000, 1'b0, '0});
        relight_script.push_back('{1'b0, '0, '0, 16'h0C00, 16'h0C00, 16'hF400, 1'b0, '0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (relight_script[n]) begin
            if (relight_script[n].is_write) begin
                wait_idle();
                write_light(relight_script[n].reg_idx, relight_script[n].reg_val);
            end else begin
                send_coefs(relight_script[n].red, relight_script[n].green,
                           relight_script[n].blue, relight_script[n].typed,
                           relight_script[n].want, 1'b0);
            end
        end

        // Random phases. A phase may end in the middle of a pixel, so the light
        // changes between phases also land on partly accumulated sums.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(30, 110);
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_len; i++) begin
                send_coefs(pick_coef(), pick_coef(), pick_coef(), 1'b0, '0, burst);
            end
            sent += phase_len;
            wait_idle();
            writes = $urandom_range(1, 3);
            for (int w = 0; w < writes; w++) begin
                write_light(CFG_IDX_W'($urandom_range(0, 3)), pick_light_value());
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
